### rtl/core/assert_macros.svh
// assertion macros shared by the rtl, clocked on clk and held off during arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TMI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tmi_pkg.sv
`default_nettype none
package tmi_pkg;
	localparam int COORD_W = 16;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int COF_W   = PROD_W + 1;
	localparam int DPROD_W = COORD_W + COF_W;
	localparam int DET_W   = DPROD_W + 2;
	localparam int MAG_W   = 48;
	localparam int OUT_W   = 24;
	localparam int IDX_W   = 8;
	localparam int DIV_STEPS = OUT_W + 1;
	localparam int PRE_STAGES = 6;
	localparam int LANE_LAT = DIV_STEPS + 1;
	localparam int NSTG = PRE_STAGES + LANE_LAT;
	localparam int NELEM = 9;
	localparam int NPROD = 18;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [OUT_W-1:0]   elem_t;
	typedef logic [MAG_W-1:0]          mag_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             sing;
	} side_t;

	localparam logic [DIV_STEPS-1:0] NEG_LIM = DIV_STEPS'(1) << (OUT_W - 1);
	localparam logic [DIV_STEPS-1:0] POS_LIM = NEG_LIM - DIV_STEPS'(1);
	localparam elem_t ELEM_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam elem_t ELEM_MAX = {1'b0, {(OUT_W-1){1'b1}}};
endpackage
`default_nettype wire

### rtl/core/tmi_in_if.sv
`default_nettype none
interface tmi_in_if;
	logic                          valid;
	logic                          ready;
	tmi_pkg::coord_t               s1_x, s1_y, s1_z;
	tmi_pkg::coord_t               s2_x, s2_y, s2_z;
	tmi_pkg::coord_t               s3_x, s3_y, s3_z;
	logic [tmi_pkg::IDX_W-1:0]     triplet_index;
	logic                          last_triplet;

	modport source (output valid, s1_x, s1_y, s1_z, s2_x, s2_y, s2_z, s3_x, s3_y, s3_z,
		triplet_index, last_triplet, input ready);
	modport sink (input valid, s1_x, s1_y, s1_z, s2_x, s2_y, s2_z, s3_x, s3_y, s3_z,
		triplet_index, last_triplet, output ready);
endinterface
`default_nettype wire

### rtl/core/tmi_out_if.sv
`default_nettype none
interface tmi_out_if;
	logic                          valid;
	logic                          ready;
	tmi_pkg::elem_t                inv_00, inv_01, inv_02;
	tmi_pkg::elem_t                inv_10, inv_11, inv_12;
	tmi_pkg::elem_t                inv_20, inv_21, inv_22;
	logic                          singular;
	logic [tmi_pkg::IDX_W-1:0]     result_index;
	logic                          result_last;

	modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
		inv_20, inv_21, inv_22, singular, result_index, result_last, input ready);
	modport sink (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
		inv_20, inv_21, inv_22, singular, result_index, result_last, output ready);
endinterface
`default_nettype wire

### rtl/core/tmi_div_lane.sv
`default_nettype none
module tmi_div_lane (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire tmi_pkg::mag_t   r0,
	input  wire tmi_pkg::mag_t   d,
	input  wire logic            neg,
	input  wire logic            ovf,
	input  wire logic            zero,
	output tmi_pkg::elem_t       res
);
	localparam int S = tmi_pkg::DIV_STEPS;

	tmi_pkg::mag_t           rem_s [1:S];
	tmi_pkg::mag_t           div_s [1:S];
	logic [S-1:0]            quo_s [1:S];
	logic [2:0]              flg_s [1:S];

	tmi_pkg::mag_t           rem_in [1:S];
	tmi_pkg::mag_t           div_in [1:S];
	logic [S-1:0]            quo_in [1:S];
	logic [2:0]              flg_in [1:S];
	tmi_pkg::mag_t           rem_nx [1:S];
	logic                    ge [1:S];

	logic [S:0]              q_inc;
	logic [S-1:0]            q_rnd;
	tmi_pkg::elem_t          res_q;

	// one quotient bit per stage, restoring
	always_comb begin
		logic [tmi_pkg::MAG_W:0] r2;
		for (int j = 1; j <= S; j++) begin
			if (j == 1) begin
				rem_in[j] = r0;
				div_in[j] = d;
				quo_in[j] = '0;
				flg_in[j] = {zero, ovf, neg};
			end else begin
				rem_in[j] = rem_s[j-1];
				div_in[j] = div_s[j-1];
				quo_in[j] = quo_s[j-1];
				flg_in[j] = flg_s[j-1];
			end
			r2 = {rem_in[j], 1'b0};
			ge[j] = (r2 >= {1'b0, div_in[j]});
			rem_nx[j] = ge[j] ? tmi_pkg::MAG_W'(r2 - {1'b0, div_in[j]})
				: r2[tmi_pkg::MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 1; j <= S; j++) begin
				rem_s[j] <= rem_nx[j];
				div_s[j] <= div_in[j];
				quo_s[j] <= {quo_in[j][S-2:0], ge[j]};
				flg_s[j] <= flg_in[j];
			end
		end
	end

	// round half away from zero on the doubled quotient
	assign q_inc = {1'b0, quo_s[S]} + (S+1)'(1);
	assign q_rnd = q_inc[S:1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_s[S][2]) begin
				res_q <= '0;
			end else if (flg_s[S][0]) begin
				if (flg_s[S][1] || (q_rnd > tmi_pkg::NEG_LIM))
					res_q <= tmi_pkg::ELEM_MIN;
				else
					res_q <= tmi_pkg::elem_t'(~q_rnd[tmi_pkg::OUT_W-1:0] + 1'b1);
			end else begin
				if (flg_s[S][1] || (q_rnd > tmi_pkg::POS_LIM))
					res_q <= tmi_pkg::ELEM_MAX;
				else
					res_q <= tmi_pkg::elem_t'(q_rnd[tmi_pkg::OUT_W-1:0]);
			end
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

### rtl/core/triplet_matrix_inverse_3x3_top.sv
// an accepted request reaches dout through the pre-stages, the divider lanes and their result register
// throughput: one triplet per cycle unless dout stalls; 25-stage bit-per-stage divider lanes
// a stalled dout freezes the whole pipeline in place, nothing is dropped or repeated
// reset (arst_n, asynchronous) clears the stage valid bits only; data is not reset
`default_nettype none
`include "assert_macros.svh"
module triplet_matrix_inverse_3x3_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmi_in_if.sink      din,
	tmi_out_if.source   dout
);
	localparam int N = tmi_pkg::NSTG;
	localparam int P = tmi_pkg::PRE_STAGES;

	logic                               adv;
	logic                               vld_s [1:N];
	tmi_pkg::side_t                     side_s [1:N];

	// stage 1: registered coordinates, one row per speaker
	tmi_pkg::vec_t                      row_s1 [3];
	// stage 2: the eighteen coordinate products
	logic signed [tmi_pkg::PROD_W-1:0]  prod_s2 [tmi_pkg::NPROD];
	tmi_pkg::vec_t                      arow_s2;
	// stage 3: signed cofactors
	logic signed [tmi_pkg::COF_W-1:0]   cof_s3 [tmi_pkg::NELEM];
	tmi_pkg::vec_t                      arow_s3;
	// stage 4: first-row expansion products
	logic signed [tmi_pkg::DPROD_W-1:0] dprod_s4 [3];
	logic signed [tmi_pkg::COF_W-1:0]   cof_s4 [tmi_pkg::NELEM];
	// stage 5: determinant
	logic signed [tmi_pkg::DET_W-1:0]   det_s5;
	logic signed [tmi_pkg::COF_W-1:0]   cof_s5 [tmi_pkg::NELEM];
	// stage 6: magnitudes, sign, overflow and the divider start value
	tmi_pkg::mag_t                      dmag_s6;
	tmi_pkg::mag_t                      r0_s6 [tmi_pkg::NELEM];
	logic                               neg_s6 [tmi_pkg::NELEM];
	logic                               ovf_s6 [tmi_pkg::NELEM];
	logic                               zero_s6;

	tmi_pkg::elem_t                     res [tmi_pkg::NELEM];

	logic signed [tmi_pkg::DET_W-1:0]   det_abs;
	logic signed [tmi_pkg::COF_W-1:0]   cof_abs [tmi_pkg::NELEM];

	function automatic logic zero_s6_nx();
		return (det_s5 == '0);
	endfunction

	// the whole pipeline moves when the output slot is empty or being taken
	assign adv = !vld_s[N] || dout.ready;
	assign din.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= N; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= din.valid;
			for (int i = 2; i <= N; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// index, marker and singular flag travel alongside
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= '{idx: din.triplet_index, last: din.last_triplet, sing: 1'b0};
			for (int i = 2; i <= N; i++) begin
				if (i == P)
					side_s[i] <= '{idx: side_s[i-1].idx, last: side_s[i-1].last,
						sing: zero_s6_nx()};
				else
					side_s[i] <= side_s[i-1];
			end
		end
	end

	always_comb begin
		det_abs = det_s5[tmi_pkg::DET_W-1] ? -det_s5 : det_s5;
		for (int k = 0; k < tmi_pkg::NELEM; k++)
			cof_abs[k] = cof_s5[k][tmi_pkg::COF_W-1] ? -cof_s5[k] : cof_s5[k];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1[0] <= '{x: din.s1_x, y: din.s1_y, z: din.s1_z};
			row_s1[1] <= '{x: din.s2_x, y: din.s2_y, z: din.s2_z};
			row_s1[2] <= '{x: din.s3_x, y: din.s3_y, z: din.s3_z};

			// b = row 1, c = row 2, a = row 0
			prod_s2[0]  <= row_s1[1].y * row_s1[2].z;
			prod_s2[1]  <= row_s1[1].z * row_s1[2].y;
			prod_s2[2]  <= row_s1[1].x * row_s1[2].z;
			prod_s2[3]  <= row_s1[1].z * row_s1[2].x;
			prod_s2[4]  <= row_s1[1].x * row_s1[2].y;
			prod_s2[5]  <= row_s1[1].y * row_s1[2].x;
			prod_s2[6]  <= row_s1[0].y * row_s1[2].z;
			prod_s2[7]  <= row_s1[0].z * row_s1[2].y;
			prod_s2[8]  <= row_s1[0].x * row_s1[2].z;
			prod_s2[9]  <= row_s1[0].z * row_s1[2].x;
			prod_s2[10] <= row_s1[0].x * row_s1[2].y;
			prod_s2[11] <= row_s1[0].y * row_s1[2].x;
			prod_s2[12] <= row_s1[0].y * row_s1[1].z;
			prod_s2[13] <= row_s1[0].z * row_s1[1].y;
			prod_s2[14] <= row_s1[0].x * row_s1[1].z;
			prod_s2[15] <= row_s1[0].z * row_s1[1].x;
			prod_s2[16] <= row_s1[0].x * row_s1[1].y;
			prod_s2[17] <= row_s1[0].y * row_s1[1].x;
			arow_s2     <= row_s1[0];

			// cofactor signs folded into the operand order
			cof_s3[0] <= prod_s2[0]  - prod_s2[1];
			cof_s3[1] <= prod_s2[3]  - prod_s2[2];
			cof_s3[2] <= prod_s2[4]  - prod_s2[5];
			cof_s3[3] <= prod_s2[7]  - prod_s2[6];
			cof_s3[4] <= prod_s2[8]  - prod_s2[9];
			cof_s3[5] <= prod_s2[11] - prod_s2[10];
			cof_s3[6] <= prod_s2[12] - prod_s2[13];
			cof_s3[7] <= prod_s2[15] - prod_s2[14];
			cof_s3[8] <= prod_s2[16] - prod_s2[17];
			arow_s3   <= arow_s2;

			dprod_s4[0] <= arow_s3.x * cof_s3[0];
			dprod_s4[1] <= arow_s3.y * cof_s3[1];
			dprod_s4[2] <= arow_s3.z * cof_s3[2];
			cof_s4      <= cof_s3;

			det_s5 <= dprod_s4[0] + dprod_s4[1] + dprod_s4[2];
			cof_s5 <= cof_s4;

			// overflow when the quotient is 2^24 or more, i.e. 4|C| >= |det|
			dmag_s6 <= det_abs[tmi_pkg::MAG_W-1:0];
			zero_s6 <= zero_s6_nx();
			for (int k = 0; k < tmi_pkg::NELEM; k++) begin
				r0_s6[k]  <= tmi_pkg::MAG_W'({cof_abs[k][tmi_pkg::PROD_W-1:0], 2'b00});
				ovf_s6[k] <= tmi_pkg::MAG_W'({cof_abs[k][tmi_pkg::PROD_W-1:0], 2'b00})
					>= det_abs[tmi_pkg::MAG_W-1:0];
				neg_s6[k] <= cof_s5[k][tmi_pkg::COF_W-1] ^ det_s5[tmi_pkg::DET_W-1];
			end
		end
	end

	// nine divider lanes share the determinant magnitude
	for (genvar k = 0; k < tmi_pkg::NELEM; k++) begin : g_lane
		tmi_div_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.r0   (r0_s6[k]),
			.d    (dmag_s6),
			.neg  (neg_s6[k]),
			.ovf  (ovf_s6[k]),
			.zero (zero_s6),
			.res  (res[k])
		);
	end

	assign dout.valid        = vld_s[N];
	assign dout.inv_00       = res[0];
	assign dout.inv_01       = res[1];
	assign dout.inv_02       = res[2];
	assign dout.inv_10       = res[3];
	assign dout.inv_11       = res[4];
	assign dout.inv_12       = res[5];
	assign dout.inv_20       = res[6];
	assign dout.inv_21       = res[7];
	assign dout.inv_22       = res[8];
	assign dout.singular     = side_s[N].sing;
	assign dout.result_index = side_s[N].idx;
	assign dout.result_last  = side_s[N].last;

	// singular results leave the lanes as zeros
	`TMI_ASSERT_NOW(a_sing_zero, dout.valid && dout.singular,
		(dout.inv_00 == '0) && (dout.inv_11 == '0) && (dout.inv_22 == '0),
		"singular result with non-zero elements")
	// an accepted request always enters the first stage
	`TMI_ASSERT_NEXT(a_enter, din.valid && din.ready, vld_s[1],
		"accepted request not captured")
	// a taken result with nothing behind it leaves the output empty
	`TMI_ASSERT_NEXT(a_drain, dout.valid && dout.ready && !vld_s[N-1], !dout.valid,
		"result repeated after hand-off")
endmodule
`default_nettype wire
